// File: hdl/uct_pkg.sv
// uct_pkg: shared types and constants for the uct best-child selector
// no dependencies
`timescale 1ns / 1ps
package uct_pkg;
    localparam int unsigned SCORE_W = 48;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [47:0] SCORE_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SCORE_MIN = {1'b1, {47{1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOG_INIT, ST_LOG_SQ, ST_LOG_NORM, ST_LN,
        ST_DIV1, ST_DIV2, ST_SQRT, ST_MUL, ST_SUM, ST_OUT
    } t_state;
endpackage

// File: hdl/uct_divider.sv
// uct_divider: restoring divider, one quotient bit per cycle
// depends on uct_pkg
`timescale 1ns / 1ps
module uct_divider
    import uct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem[31:0], r_num[63]};
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem = w_trial - {1'b0, i_den};
                n_num = {r_num[62:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_num = {r_num[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    // last quotient bit formed in the done cycle, independent of a new start
    assign o_done = r_busy && (r_cnt == 7'd63);
    assign o_quot = {r_num[62:0], (w_trial >= {1'b0, i_den})};
endmodule

// File: hdl/uct_best_child_select.sv
// uct_best_child_select: streaming uct best-child selector, top level
// depends on uct_pkg and uct_divider
//
// usage: one child per input item (valid/stall). each child is scored as
// reward/visits + w*sqrt(2*ln(parent)/visits) in signed q.16; the running
// maximum (first wins ties) is kept. on an item with last_child set, or
// the MAX_CHILDREN-th child of a selection, one result item carries the
// best index and score and the running state clears.
// per item: log2 takes 16 squaring steps, each a square and a normalise
// state, then two passes of the shared restoring divider, a 32-step
// bit-pair square root, a multiply and a sum. the result is registered
// in ST_OUT, and the next item is taken only once the block is back in
// ST_IDLE with no result pending. the input stalls for the whole item.
// a child with zero visits skips the math.
// o_valid holds until taken; while the output is stalled the block does
// not take a new item. i_cfg_we writes the weight any time the block idles.
// reset: weight 1.0, running best cleared, no result pending.
`timescale 1ns / 1ps
module uct_best_child_select
    import uct_pkg::*;
#(
    parameter int unsigned MAX_CHILDREN = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_parent_visits,
    input  logic signed [31:0] i_child_reward,
    input  logic [31:0]        i_child_visits,
    input  logic [7:0]         i_child_index,
    input  logic               i_exploit_only,
    input  logic               i_last_child,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_best_index,
    output logic signed [47:0] o_best_score
);
    localparam int CNT_W = $clog2(MAX_CHILDREN + 1);

    t_state r_state, n_state;
    logic [16:0] r_weight;
    logic [31:0] r_parent, r_visits;
    logic        r_neg, r_last;
    logic [7:0]  r_idx;
    logic [16:0] r_w;
    logic [32:0] r_m;
    logic [63:0] r_sq;
    logic [15:0] r_frac;
    logic [4:0]  r_k, r_step;
    logic [31:0] r_acc;
    logic signed [48:0] r_exploit;
    logic [63:0] r_v, r_res, r_bit;
    logic signed [47:0] r_score, r_best;
    logic [7:0]  r_best_idx;
    logic        r_started;
    logic [CNT_W-1:0] r_cnt;
    logic        r_oval;

    logic        w_div_start, w_div_done;
    logic [63:0] w_div_num, w_div_quot;
    logic [4:0]  w_msb;
    logic [63:0] w_sum;
    logic signed [48:0] w_total;
    logic        w_take;

    uct_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(r_visits), .o_done(w_div_done),
        .o_quot(w_div_quot)
    );

    always_comb begin
        w_msb = 5'd0;
        for (int i = 0; i < 32; i++) if (r_parent[i]) w_msb = 5'(i);
    end

    assign o_stall = (r_state != ST_IDLE) || r_oval;
    assign w_sum = r_res + r_bit;
    assign w_total = r_exploit + $signed({1'b0, r_res[47:0]});
    assign w_take = !r_started || (r_score > r_best);

    always_comb begin
        n_state = r_state;
        w_div_start = 1'b0;
        w_div_num = '0;
        unique case (r_state)
            ST_IDLE:     if (i_valid && !o_stall) n_state = ST_LOG_INIT;
            ST_LOG_INIT: n_state = (r_visits == '0) ? ST_SUM : ST_LOG_SQ;
            ST_LOG_SQ:   n_state = ST_LOG_NORM;
            ST_LOG_NORM: n_state = (r_step == 5'd15) ? ST_LN : ST_LOG_SQ;
            ST_LN: begin
                w_div_start = 1'b1;
                w_div_num = {16'd0, r_acc, 16'd0};
                n_state = ST_DIV1;
            end
            ST_DIV1: if (w_div_done) begin
                w_div_start = 1'b1;
                w_div_num = {r_sq[46:0], 17'd0};
                n_state = ST_DIV2;
            end
            ST_DIV2: if (w_div_done) n_state = ST_SQRT;
            ST_SQRT: if (r_bit == '0) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_weight <= WEIGHT_ONE;
            r_best <= '0;
            r_best_idx <= '0;
            r_started <= 1'b0;
            r_cnt <= '0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_weight <= i_cfg_wdata;
            if (r_oval && !i_stall) r_oval <= 1'b0;
            if (r_state == ST_OUT) begin
                if (r_last || (32'(r_cnt) + 32'd1 >= MAX_CHILDREN)) begin
                    o_best_index <= w_take ? r_idx : r_best_idx;
                    o_best_score <= w_take ? r_score : r_best;
                    r_oval <= 1'b1;
                    r_best <= '0;
                    r_best_idx <= '0;
                    r_started <= 1'b0;
                    r_cnt <= '0;
                end else begin
                    if (w_take) begin
                        r_best <= r_score;
                        r_best_idx <= r_idx;
                    end
                    r_started <= 1'b1;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
        unique case (r_state)
            ST_IDLE: begin
                r_parent <= i_parent_visits;
                r_visits <= i_child_visits;
                r_neg <= i_child_reward[31];
                r_acc <= i_child_reward[31] ? 32'(-i_child_reward)
                                            : 32'(i_child_reward);
                r_idx <= i_child_index;
                r_last <= i_last_child;
                r_w <= i_exploit_only ? 17'd0
                       : (r_weight > WEIGHT_ONE ? WEIGHT_ONE : r_weight);
            end
            ST_LOG_INIT: begin
                r_m <= 33'({r_parent, 31'd0} >> w_msb);
                r_k <= w_msb;
                r_frac <= '0;
                r_step <= '0;
                r_exploit <= '0;
            end
            ST_LOG_SQ: r_sq <= 64'(r_m) * 64'(r_m);
            ST_LOG_NORM: begin
                r_step <= r_step + 5'd1;
                if (r_sq[63:31] >= 33'h1_0000_0000) begin
                    r_m <= r_sq[64-1:32];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_m <= r_sq[63:31];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
            end
            ST_LN: begin
                r_sq <= (r_parent == '0) ? 64'd0
                        : (64'({r_k, r_frac}) * 64'(LN2_Q32)) >> 32;
            end
            ST_DIV1: if (w_div_done) begin
                r_exploit <= r_neg ? -49'(w_div_quot[47:0]) : 49'(w_div_quot[47:0]);
            end
            ST_DIV2: if (w_div_done) begin
                r_v <= w_div_quot;
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            ST_SQRT: if (r_bit != '0) begin
                if (r_v >= w_sum) begin
                    r_v <= r_v - w_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_MUL: r_res <= (64'(r_w) * r_res) >> 16;
            ST_SUM: begin
                if (r_visits == '0) r_score <= SCORE_MAX;
                else if (w_total > 49'(SCORE_MAX)) r_score <= SCORE_MAX;
                else if (w_total < 49'sh1_8000_0000_0000) r_score <= SCORE_MIN;
                else r_score <= w_total[47:0];
            end
            default: ;
        endcase
    end

    assign o_valid = r_oval;
endmodule

// File: hdl/uct_checker.sv
// uct_checker: port-level assertions for uct_best_child_select
// depends on the top level's ports only
`timescale 1ns / 1ps
module uct_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic [7:0] o_best_index
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_best_index)) else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("took item while busy");
    a_outstall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open with result pending");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");
endmodule

bind uct_best_child_select uct_checker u_chk (.*);

// File: sim/uct_best_child_select_test.sv
// uct_best_child_select_test: self-checking bench for the uct best-child selector
// drives children through valid/stall, predicts each selection's result and compares
// depends on uct_pkg and uct_best_child_select
`timescale 1ns / 1ps
module uct_best_child_select_test;
    import uct_pkg::*;

    localparam int unsigned NUM_CHILD_MAX = 256;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 250;

    typedef struct packed {
        logic [31:0] parent_visits;
        logic [31:0] child_reward;
        logic [31:0] child_visits;
        logic [7:0]  child_index;
        logic        exploit_only;
        logic        last_child;
    } t_child;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [16:0]        i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [31:0]        i_parent_visits = '0;
    logic signed [31:0] i_child_reward = '0;
    logic [31:0]        i_child_visits = '0;
    logic [7:0]         i_child_index = '0;
    logic               i_exploit_only = 1'b0;
    logic               i_last_child = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_best_index;
    logic signed [47:0] o_best_score;

    uct_best_child_select dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_parent_visits(i_parent_visits), .i_child_reward(i_child_reward),
        .i_child_visits(i_child_visits), .i_child_index(i_child_index),
        .i_exploit_only(i_exploit_only), .i_last_child(i_last_child),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_best_index(o_best_index), .o_best_score(o_best_score)
    );

    always #2 i_clk = ~i_clk;

    t_child      pending_children[$];
    logic [7:0]  best_index_q[$];
    longint      best_score_q[$];

    logic [16:0] weight_copy = WEIGHT_ONE;
    longint      sel_best_score = 0;
    logic [7:0]  sel_best_index = '0;
    bit          sel_started = 0;
    int unsigned sel_count = 0;

    int     error_count = 0;
    int     children_sent = 0;
    int     results_checked = 0;
    longint cycle_count = 0;

    function automatic longint unsigned log2_fixed(logic [31:0] p);
        int k;
        longint unsigned m;
        longint unsigned frac;
        k = 0;
        frac = 0;
        if (p == 0) return 0;
        while (k < 31 && (p >> (k + 1)) != 0) k++;
        m = longint'(p) << (31 - k);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(k) << 16) | frac;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint uct_score_of(t_child c, logic [16:0] w);
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned ln_q;
        longint unsigned t;
        longint exploit;
        longint explore;
        longint sum;
        logic signed [31:0] r;
        longint maxv;
        longint minv;
        maxv = longint'(SCORE_MAX);
        minv = longint'(SCORE_MIN);
        if (c.child_visits == 0) return maxv;
        r = c.child_reward;
        mag = (r < 0) ? longint'(-longint'(r)) : longint'(r);
        quo = (mag << 16) / longint'(c.child_visits);
        exploit = (r < 0) ? -longint'(quo) : longint'(quo);
        ln_q = (log2_fixed(c.parent_visits) * longint'(LN2_Q32)) >> 32;
        t = ((2 * ln_q) << 16) / longint'(c.child_visits);
        if (w > WEIGHT_ONE) w = WEIGHT_ONE;
        explore = longint'((longint'(w) * floor_sqrt(t)) >> 16);
        sum = exploit + explore;
        if (sum > maxv) sum = maxv;
        if (sum < minv) sum = minv;
        return sum;
    endfunction

    task automatic predict_selection(t_child c);
        longint s;
        bit     done;
        s = uct_score_of(c, c.exploit_only ? 17'd0 : weight_copy);
        if (!sel_started || s > sel_best_score) begin
            sel_best_score = s;
            sel_best_index = c.child_index;
        end
        sel_started = 1;
        sel_count++;
        done = c.last_child || sel_count >= NUM_CHILD_MAX;
        if (done) begin
            best_index_q.push_back(sel_best_index);
            best_score_q.push_back(sel_best_score);
            sel_best_score = 0;
            sel_best_index = '0;
            sel_started = 0;
            sel_count = 0;
        end
    endtask

    // driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left = 0;
    t_child next_child;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_selection({i_parent_visits, i_child_reward, i_child_visits,
                                   i_child_index, i_exploit_only, i_last_child});
                children_sent++;
            end
            if (i_valid && o_stall) begin
                // hold the stalled item
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_children.size() > 0) begin
                next_child = pending_children.pop_front();
                i_parent_visits <= next_child.parent_visits;
                i_child_reward <= next_child.child_reward;
                i_child_visits <= next_child.child_visits;
                i_child_index <= next_child.child_index;
                i_exploit_only <= next_child.exploit_only;
                i_last_child <= next_child.last_child;
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: checks results and stalls on its own pattern
    int stall_mode = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("uct_best_child_select_test: errors");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            if (best_index_q.size() == 0) begin
                $display("%0t: unexpected result index %0d score %0d", $time,
                         o_best_index, o_best_score);
                error_count++;
            end else begin
                if (o_best_index !== best_index_q[0]) begin
                    $display("%0t: best_index expected %0d actual %0d", $time,
                             best_index_q[0], o_best_index);
                    error_count++;
                end
                if (o_best_score !== best_score_q[0][47:0]) begin
                    $display("%0t: best_score expected %0d actual %0d", $time,
                             best_score_q[0], o_best_score);
                    error_count++;
                end
                void'(best_index_q.pop_front());
                void'(best_score_q.pop_front());
            end
        end
        if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 0);
            2: i_stall <= ($urandom_range(0, 9) != 0);
            default: i_stall <= (cycle_count % 5 < 2);
        endcase
    end

    task automatic add_child(logic [31:0] p, logic [31:0] r, logic [31:0] v,
                             logic [7:0] idx, logic eo, logic last);
        t_child c;
        c.parent_visits = p;
        c.child_reward = r;
        c.child_visits = v;
        c.child_index = idx;
        c.exploit_only = eo;
        c.last_child = last;
        pending_children.push_back(c);
    endtask

    function automatic logic [31:0] rand_visits();
        case ($urandom_range(0, 9))
            0: return 0;
            1, 2: return $urandom;
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [31:0] rand_parent();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 1;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    function automatic logic [31:0] rand_reward();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic add_selection(int n, bit close);
        logic [31:0] p;
        p = rand_parent();
        for (int i = 0; i < n; i++)
            add_child(p, rand_reward(), rand_visits(), 8'($urandom),
                      ($urandom_range(0, 4) == 0), close && (i == n - 1));
    endtask

    task automatic settle_and_write(logic [16:0] w);
        wait (pending_children.size() == 0 && !i_valid);
        wait (best_index_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        weight_copy = w;
    endtask

    task automatic random_phase(int n_items);
        int queued;
        queued = 0;
        while (queued < n_items) begin
            int n;
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            add_selection(n, 1);
            queued += n;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settle_and_write(WEIGHT_ONE);

        add_child(32'd1, 32'd0, 32'd1, 8'd0, 1'b0, 1'b1);
        add_child(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 8'd255, 1'b0, 1'b1);
        add_child(32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 8'd1, 1'b1, 1'b1);
        add_child(32'd100, 32'd50, 32'd4, 8'd2, 1'b0, 1'b0);
        add_child(32'd100, 32'd9, 32'd0, 8'd7, 1'b0, 1'b0);
        add_child(32'd100, 32'd9, 32'd0, 8'd8, 1'b0, 1'b1);
        add_child(32'd0, 32'd5, 32'd3, 8'd3, 1'b0, 1'b1);
        add_child(32'd77, 32'd12, 32'd6, 8'd10, 1'b0, 1'b0);
        add_child(32'd77, 32'd12, 32'd6, 8'd11, 1'b0, 1'b1);
        add_child(32'd1000, 32'h8000_0000, 32'hFFFF_FFFF, 8'd20, 1'b0, 1'b0);
        add_child(32'd1000, 32'hFFFF_FFF0, 32'd2, 8'd21, 1'b0, 1'b0);
        add_child(32'd1000, 32'hFFFF_FFFF, 32'd1, 8'd22, 1'b1, 1'b1);
        add_child(32'h8000_0000, 32'd3, 32'd1, 8'd30, 1'b0, 1'b0);
        add_child(32'h8000_0000, 32'd3, 32'd1, 8'd31, 1'b1, 1'b1);
        random_phase(300);

        settle_and_write(17'd0);
        add_child(32'd64, 32'd1, 32'd2, 8'd40, 1'b0, 1'b1);
        random_phase(250);

        settle_and_write(17'h1FFFF);
        add_child(32'd64, 32'd1, 32'd2, 8'd41, 1'b0, 1'b1);
        random_phase(250);

        // an open selection that runs into the child limit
        settle_and_write(17'd32768);
        add_selection(NUM_CHILD_MAX + 5, 0);
        add_selection(3, 1);

        settle_and_write(17'($urandom_range(1, 65535)));
        random_phase(350);

        wait (pending_children.size() == 0 && !i_valid);
        wait (best_index_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d children and %0d selections over five weight settings",
                 children_sent, results_checked);
        if (error_count == 0 && best_index_q.size() == 0) begin
            $display("uct_best_child_select_test: clean");
        end else begin
            $display("uct_best_child_select_test: errors");
        end
        $finish;
    end
endmodule
